// ===== design/rtnh_pkg.sv =====
// Shared types, codes and helpers for the nearest ray/triangle hit engine.
// No dependencies; used by every module of the block.
`default_nettype none

package rtnh_pkg;

  localparam int unsigned DefMaxTriangles = 65536;
  localparam int unsigned DefFractionBits = 16;

  typedef logic [31:0]      word_t;
  typedef logic [2:0][31:0] vec_t;

  // One queued triangle: vertices a, b, c (x, y, z each), last flag, stream number
  typedef struct packed {
    logic [8:0][31:0] vtx;
    logic             last;
    logic [15:0]      number;
  } tri_t;

  typedef enum logic [1:0] {
    ST_NO_HIT   = 2'd0,
    ST_HIT      = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  // Multiplier operand sources
  typedef enum logic [4:0] {
    SRC_DIR_X, SRC_DIR_Y, SRC_DIR_Z,
    SRC_E1_X,  SRC_E1_Y,  SRC_E1_Z,
    SRC_E2_X,  SRC_E2_Y,  SRC_E2_Z,
    SRC_TV_X,  SRC_TV_Y,  SRC_TV_Z,
    SRC_P_X,   SRC_P_Y,   SRC_P_Z,
    SRC_Q_X,   SRC_Q_Y,   SRC_Q_Z
  } src_t;

  typedef enum logic [1:0] {
    ACC_SET,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_P_X, DST_P_Y, DST_P_Z,
    DST_Q_X, DST_Q_Y, DST_Q_Z,
    DST_DET,
    DST_NUM
  } dst_t;

  typedef struct packed {
    src_t    a;
    src_t    b;
    acc_op_t op;
    dst_t    dst;
  } step_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SUB,
    BK_MUL,
    BK_ACC,
    BK_DIV,
    BK_CHK,
    BK_DONE,
    BK_FMUL,
    BK_FACC,
    BK_EMIT
  } back_state_t;

  // Divider request and response
  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } div_rsp_t;

  // Program counter marks: numerators of u, v and t
  localparam logic [4:0] PcU = 5'd11;
  localparam logic [4:0] PcV = 5'd20;
  localparam logic [4:0] PcT = 5'd23;

  // Saturate a wide signed value to 32 bits
  function automatic word_t sat32(logic signed [65:0] x);
    word_t r;
    if (x > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Saturating difference a - b
  function automatic word_t sub_sat(word_t a, word_t b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return sat32(66'(d));
  endfunction

  // Micro program: cross products, dot products and numerators
  function automatic step_t prog_step(logic [4:0] pc);
    step_t s;
    case (pc)
      5'd0:    s = '{SRC_DIR_Y, SRC_E2_Z, ACC_SET, DST_NONE};
      5'd1:    s = '{SRC_DIR_Z, SRC_E2_Y, ACC_SUB, DST_P_X};
      5'd2:    s = '{SRC_DIR_Z, SRC_E2_X, ACC_SET, DST_NONE};
      5'd3:    s = '{SRC_DIR_X, SRC_E2_Z, ACC_SUB, DST_P_Y};
      5'd4:    s = '{SRC_DIR_X, SRC_E2_Y, ACC_SET, DST_NONE};
      5'd5:    s = '{SRC_DIR_Y, SRC_E2_X, ACC_SUB, DST_P_Z};
      5'd6:    s = '{SRC_E1_X,  SRC_P_X,  ACC_SET, DST_NONE};
      5'd7:    s = '{SRC_E1_Y,  SRC_P_Y,  ACC_ADD, DST_NONE};
      5'd8:    s = '{SRC_E1_Z,  SRC_P_Z,  ACC_ADD, DST_DET};
      5'd9:    s = '{SRC_TV_X,  SRC_P_X,  ACC_SET, DST_NONE};
      5'd10:   s = '{SRC_TV_Y,  SRC_P_Y,  ACC_ADD, DST_NONE};
      5'd11:   s = '{SRC_TV_Z,  SRC_P_Z,  ACC_ADD, DST_NUM};
      5'd12:   s = '{SRC_TV_Y,  SRC_E1_Z, ACC_SET, DST_NONE};
      5'd13:   s = '{SRC_TV_Z,  SRC_E1_Y, ACC_SUB, DST_Q_X};
      5'd14:   s = '{SRC_TV_Z,  SRC_E1_X, ACC_SET, DST_NONE};
      5'd15:   s = '{SRC_TV_X,  SRC_E1_Z, ACC_SUB, DST_Q_Y};
      5'd16:   s = '{SRC_TV_X,  SRC_E1_Y, ACC_SET, DST_NONE};
      5'd17:   s = '{SRC_TV_Y,  SRC_E1_X, ACC_SUB, DST_Q_Z};
      5'd18:   s = '{SRC_DIR_X, SRC_Q_X,  ACC_SET, DST_NONE};
      5'd19:   s = '{SRC_DIR_Y, SRC_Q_Y,  ACC_ADD, DST_NONE};
      5'd20:   s = '{SRC_DIR_Z, SRC_Q_Z,  ACC_ADD, DST_NUM};
      5'd21:   s = '{SRC_E2_X,  SRC_Q_X,  ACC_SET, DST_NONE};
      5'd22:   s = '{SRC_E2_Y,  SRC_Q_Y,  ACC_ADD, DST_NONE};
      5'd23:   s = '{SRC_E2_Z,  SRC_Q_Z,  ACC_ADD, DST_NUM};
      default: s = '{SRC_DIR_X, SRC_DIR_X, ACC_SET, DST_NONE};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/rtnh_front.sv =====
// Input side: takes triangle items, numbers them in stream order, pushes to the queue.
// Depends on rtnh_pkg.
`default_nettype none

module rtnh_front #(
  parameter int unsigned MAX_TRIANGLES = rtnh_pkg::DefMaxTriangles
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [287:0]  s_data,
  input  logic          s_last,
  input  logic          q_full,
  output logic          push,
  output rtnh_pkg::tri_t push_item
);

  localparam int unsigned CntW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

  logic [CntW-1:0]    cnt;
  logic [CntW+15:0]   cnt_ext;

  // Accept while the queue has room
  assign s_ready = !q_full;
  assign push    = s_valid && !q_full;
  assign cnt_ext = {16'b0, cnt};

  always_comb begin
    push_item.vtx    = s_data;
    push_item.last   = s_last;
    push_item.number = cnt_ext[15:0];
  end

  // Advance the stream position; wrap at the limit, clear after the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      if (s_last || cnt == CntW'(MAX_TRIANGLES - 1)) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rtnh_queue.sv =====
// Two-entry queue of triangle items between the front and back parts.
// Depends on rtnh_pkg.
`default_nettype none

module rtnh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rtnh_pkg::tri_t push_item,
  output logic           full,
  output logic           valid,
  output rtnh_pkg::tri_t item,
  input  logic           pop
);

  rtnh_pkg::tri_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign item  = mem[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rtnh_div.sv =====
// Iterative signed divider: (num << FRACTION_BITS) / den, truncated, saturated to 32 bits.
// One quotient bit per cycle. Depends on rtnh_pkg.
`default_nettype none

module rtnh_div #(
  parameter int unsigned FRACTION_BITS = rtnh_pkg::DefFractionBits
) (
  input  logic               clk,
  input  logic               rst,
  input  rtnh_pkg::div_req_t req,
  output rtnh_pkg::div_rsp_t rsp
);

  localparam int unsigned NumW = 32 + FRACTION_BITS;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo;
  logic [32:0]     rem;
  logic [31:0]     dmag;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic            fin;
  logic [32:0]     rem_sh;
  logic            fits;
  logic [31:0]     nmag;
  logic [31:0]     dmag_in;

  // One restoring step
  always_comb begin
    rem_sh  = {rem[31:0], quo[NumW-1]};
    fits    = (rem_sh >= {1'b0, dmag});
    nmag    = req.num[31] ? (32'd0 - req.num) : req.num;
    dmag_in = req.den[31] ? (32'd0 - req.den) : req.den;
  end

  // Saturate and sign the magnitude
  always_comb begin
    rsp.done = fin;
    if (!neg) begin
      rsp.quo = (quo > NumW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
    end else begin
      rsp.quo = (quo > NumW'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
    end
  end

  // Load operands, then shift in one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= {nmag, {FRACTION_BITS{1'b0}}};
      rem  <= '0;
      dmag <= dmag_in;
      neg  <= req.num[31] ^ req.den[31];
    end else if (cnt != '0) begin
      quo <= {quo[NumW-2:0], fits};
      rem <= fits ? (rem_sh - {1'b0, dmag}) : rem_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        cnt <= CntW'(NumW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          fin <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rtnh_back.sv =====
// Back part: runs the ray test per triangle on one shared multiplier and the divider,
// keeps the nearest hit and emits the result. Depends on rtnh_pkg and rtnh_div.
`default_nettype none

module rtnh_back #(
  parameter int unsigned FRACTION_BITS = rtnh_pkg::DefFractionBits
) (
  input  logic           clk,
  input  logic           rst,
  input  rtnh_pkg::vec_t origin,
  input  rtnh_pkg::vec_t dir,
  input  logic           q_valid,
  input  rtnh_pkg::tri_t q_item,
  output logic           q_pop,
  output logic           m_valid,
  input  logic           m_ready,
  output logic [1:0]     m_status,
  output logic [207:0]   m_data
);

  localparam logic signed [31:0] OnePlus = (32'sd1 <<< FRACTION_BITS) + 32'sd1;

  rtnh_pkg::back_state_t state, state_next;
  rtnh_pkg::div_req_t    div_req;
  rtnh_pkg::div_rsp_t    div_rsp;
  rtnh_pkg::step_t       step;

  logic [8:0][31:0]    vtx;
  logic                last;
  logic [15:0]         number;
  rtnh_pkg::vec_t      e1, e2, tv, p, q, hitp;
  rtnh_pkg::word_t     det, u, v, t;
  logic [4:0]          pc;
  logic [2:0]          fidx;
  logic [1:0]          fcomp;
  logic signed [63:0]  prod;
  logic signed [65:0]  acc, acc_new, mq;
  logic [65:0]         len;
  rtnh_pkg::word_t     acc_sat;
  rtnh_pkg::word_t     opa, opb, mul_a, mul_b;
  logic                det_skip, u_fail, v_fail, t_ok, emit_go, zero_dir;
  rtnh_pkg::word_t     uv;
  logic [30:0]         nearest_dist;
  logic [15:0]         nearest_num;
  rtnh_pkg::word_t     nearest_u, nearest_v;
  logic                hit_found;
  rtnh_pkg::status_t   status;

  rtnh_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic rtnh_pkg::word_t pick(rtnh_pkg::src_t s);
    rtnh_pkg::word_t r;
    case (s)
      rtnh_pkg::SRC_DIR_X: r = dir[0];
      rtnh_pkg::SRC_DIR_Y: r = dir[1];
      rtnh_pkg::SRC_DIR_Z: r = dir[2];
      rtnh_pkg::SRC_E1_X:  r = e1[0];
      rtnh_pkg::SRC_E1_Y:  r = e1[1];
      rtnh_pkg::SRC_E1_Z:  r = e1[2];
      rtnh_pkg::SRC_E2_X:  r = e2[0];
      rtnh_pkg::SRC_E2_Y:  r = e2[1];
      rtnh_pkg::SRC_E2_Z:  r = e2[2];
      rtnh_pkg::SRC_TV_X:  r = tv[0];
      rtnh_pkg::SRC_TV_Y:  r = tv[1];
      rtnh_pkg::SRC_TV_Z:  r = tv[2];
      rtnh_pkg::SRC_P_X:   r = p[0];
      rtnh_pkg::SRC_P_Y:   r = p[1];
      rtnh_pkg::SRC_P_Z:   r = p[2];
      rtnh_pkg::SRC_Q_X:   r = q[0];
      rtnh_pkg::SRC_Q_Y:   r = q[1];
      rtnh_pkg::SRC_Q_Z:   r = q[2];
      default:             r = '0;
    endcase
    return r;
  endfunction

  // Operand selection, product scaling, accumulate and tests
  always_comb begin
    step  = rtnh_pkg::prog_step(pc);
    opa   = pick(step.a);
    opb   = pick(step.b);
    fcomp = (fidx < 3'd3) ? fidx[1:0] : 2'(fidx - 3'd3);
    if (state == rtnh_pkg::BK_FMUL) begin
      mul_a = dir[fcomp];
      mul_b = (fidx < 3'd3) ? dir[fcomp] : {1'b0, nearest_dist};
    end else begin
      mul_a = opa;
      mul_b = opb;
    end
    mq = 66'(prod) >>> FRACTION_BITS;
    case (step.op)
      rtnh_pkg::ACC_SET: acc_new = mq;
      rtnh_pkg::ACC_ADD: acc_new = acc + mq;
      rtnh_pkg::ACC_SUB: acc_new = acc - mq;
      default:           acc_new = mq;
    endcase
    acc_sat  = rtnh_pkg::sat32(acc_new);
    det_skip = ($signed(acc_sat) <= 32'sd1) && ($signed(acc_sat) >= -32'sd1);
    u_fail   = ($signed(u) < -32'sd1) || ($signed(u) > OnePlus);
    uv       = rtnh_pkg::sat32(66'($signed(u)) + 66'($signed(v)));
    v_fail   = ($signed(v) < -32'sd1) || ($signed(uv) > OnePlus);
    t_ok     = ($signed(t) > 32'sd1) && (t[30:0] < nearest_dist);
    emit_go  = !m_valid || m_ready;
    zero_dir = ((len >> FRACTION_BITS) <= 66'd1);
    if (zero_dir) begin
      status = rtnh_pkg::ST_ZERO_DIR;
    end else if (hit_found) begin
      status = rtnh_pkg::ST_HIT;
    end else begin
      status = rtnh_pkg::ST_NO_HIT;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = acc_sat;
    div_req.den   = det;
    case (state)
      rtnh_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = rtnh_pkg::BK_SUB;
        end
      end
      rtnh_pkg::BK_SUB: state_next = rtnh_pkg::BK_MUL;
      rtnh_pkg::BK_MUL: state_next = rtnh_pkg::BK_ACC;
      rtnh_pkg::BK_ACC: begin
        case (step.dst)
          rtnh_pkg::DST_DET: begin
            state_next = det_skip ? rtnh_pkg::BK_DONE : rtnh_pkg::BK_MUL;
          end
          rtnh_pkg::DST_NUM: begin
            div_req.start = 1'b1;
            state_next    = rtnh_pkg::BK_DIV;
          end
          default: state_next = rtnh_pkg::BK_MUL;
        endcase
      end
      rtnh_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_next = rtnh_pkg::BK_CHK;
        end
      end
      rtnh_pkg::BK_CHK: begin
        if (pc == rtnh_pkg::PcT || (pc == rtnh_pkg::PcU && u_fail) ||
            (pc == rtnh_pkg::PcV && v_fail)) begin
          state_next = rtnh_pkg::BK_DONE;
        end else begin
          state_next = rtnh_pkg::BK_MUL;
        end
      end
      rtnh_pkg::BK_DONE: state_next = last ? rtnh_pkg::BK_FMUL : rtnh_pkg::BK_IDLE;
      rtnh_pkg::BK_FMUL: state_next = rtnh_pkg::BK_FACC;
      rtnh_pkg::BK_FACC: begin
        state_next = (fidx == 3'd5) ? rtnh_pkg::BK_EMIT : rtnh_pkg::BK_FMUL;
      end
      rtnh_pkg::BK_EMIT: begin
        if (emit_go) begin
          state_next = rtnh_pkg::BK_IDLE;
        end
      end
      default: state_next = rtnh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtnh_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control, nearest-hit state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= '0;
      fidx         <= '0;
      nearest_dist <= '1;
      nearest_num  <= '0;
      nearest_u    <= '0;
      nearest_v    <= '0;
      hit_found    <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      // Load a new result or drop the one just taken
      if (state == rtnh_pkg::BK_EMIT && emit_go) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      case (state)
        rtnh_pkg::BK_IDLE: pc <= '0;
        rtnh_pkg::BK_ACC: begin
          if (step.dst != rtnh_pkg::DST_NUM) begin
            pc <= pc + 5'd1;
          end
        end
        rtnh_pkg::BK_CHK: begin
          pc <= pc + 5'd1;
          if (pc == rtnh_pkg::PcT && t_ok) begin
            nearest_dist <= t[30:0];
            nearest_num  <= number;
            nearest_u    <= u;
            nearest_v    <= v;
            hit_found    <= 1'b1;
          end
        end
        rtnh_pkg::BK_DONE: fidx <= '0;
        rtnh_pkg::BK_FACC: fidx <= fidx + 3'd1;
        rtnh_pkg::BK_EMIT: begin
          if (emit_go) begin
            nearest_dist <= '1;
            nearest_num  <= '0;
            nearest_u    <= '0;
            nearest_v    <= '0;
            hit_found    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rtnh_pkg::BK_IDLE: begin
        if (q_valid) begin
          vtx    <= q_item.vtx;
          last   <= q_item.last;
          number <= q_item.number;
        end
      end
      rtnh_pkg::BK_SUB: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= rtnh_pkg::sub_sat(vtx[3 + i], vtx[i]);
          e2[i] <= rtnh_pkg::sub_sat(vtx[6 + i], vtx[i]);
          tv[i] <= rtnh_pkg::sub_sat(origin[i], vtx[i]);
        end
      end
      rtnh_pkg::BK_MUL, rtnh_pkg::BK_FMUL: begin
        prod <= $signed(mul_a) * $signed(mul_b);
      end
      rtnh_pkg::BK_ACC: begin
        acc <= acc_new;
        case (step.dst)
          rtnh_pkg::DST_P_X: p[0] <= acc_sat;
          rtnh_pkg::DST_P_Y: p[1] <= acc_sat;
          rtnh_pkg::DST_P_Z: p[2] <= acc_sat;
          rtnh_pkg::DST_Q_X: q[0] <= acc_sat;
          rtnh_pkg::DST_Q_Y: q[1] <= acc_sat;
          rtnh_pkg::DST_Q_Z: q[2] <= acc_sat;
          rtnh_pkg::DST_DET: det  <= acc_sat;
          default: ;
        endcase
      end
      rtnh_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          if (pc == rtnh_pkg::PcU) begin
            u <= div_rsp.quo;
          end else if (pc == rtnh_pkg::PcV) begin
            v <= div_rsp.quo;
          end else begin
            t <= div_rsp.quo;
          end
        end
      end
      rtnh_pkg::BK_DONE: len <= '0;
      rtnh_pkg::BK_FACC: begin
        if (fidx < 3'd3) begin
          len <= len + 66'(prod);
        end else begin
          hitp[fcomp] <= rtnh_pkg::sat32(66'($signed(origin[fcomp])) + mq);
        end
      end
      rtnh_pkg::BK_EMIT: begin
        if (emit_go) begin
          m_status <= status;
          if (status == rtnh_pkg::ST_HIT) begin
            m_data <= {1'b0, hitp[2], hitp[1], hitp[0], nearest_v, nearest_u,
                       nearest_dist, nearest_num};
          end else begin
            m_data <= '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ray_triangle_nearest_hit_top.sv =====
// Nearest ray/triangle hit engine: each triangle runs on the shared multiplier and the
// one-bit-per-cycle divider and ends early when a test rejects it; the item marked last
// also computes the direction length and the hit point before its result.
// A two-item queue lets input items arrive while the back part works or a result waits.
// Synchronous reset clears the stream state and sets the ray to origin 0, direction -z.
`default_nettype none

module ray_triangle_nearest_hit_top #(
  parameter int unsigned MAX_TRIANGLES = rtnh_pkg::DefMaxTriangles,
  parameter int unsigned FRACTION_BITS = rtnh_pkg::DefFractionBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic         s_axis_tlast,  // last_triangle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // triangle_number, hit_distance, weight_u, weight_v, hit_x, hit_y, hit_z, zero pad
  output logic [207:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,  // status
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [31:0] OneFx = 32'd1 << FRACTION_BITS;

  rtnh_pkg::vec_t origin;
  rtnh_pkg::vec_t dir;
  rtnh_pkg::tri_t push_item;
  rtnh_pkg::tri_t q_item;
  logic           push, q_full, q_valid, q_pop;

  // Ray registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      dir[0] <= '0;
      dir[1] <= '0;
      dir[2] <= 32'd0 - OneFx;
    end else if (cfg_we) begin
      case (rtnh_pkg::cfg_reg_t'(cfg_index))
        rtnh_pkg::REG_ORIGIN_X: origin[0] <= cfg_data;
        rtnh_pkg::REG_ORIGIN_Y: origin[1] <= cfg_data;
        rtnh_pkg::REG_ORIGIN_Z: origin[2] <= cfg_data;
        rtnh_pkg::REG_DIR_X:    dir[0]    <= cfg_data;
        rtnh_pkg::REG_DIR_Y:    dir[1]    <= cfg_data;
        rtnh_pkg::REG_DIR_Z:    dir[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  rtnh_front #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_data    (s_axis_tdata),
    .s_last    (s_axis_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rtnh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .item      (q_item),
    .pop       (q_pop)
  );

  rtnh_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .origin   (origin),
    .dir      (dir),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_status (m_axis_tuser),
    .m_data   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== dv/ray_triangle_nearest_hit_top_tb.sv =====
// Testbench for ray_triangle_nearest_hit_top: streams triangle meshes, predicts the nearest
// hit per mesh in a scoreboard class and checks every result item field by field.
// Depends on rtnh_pkg and the ray_triangle_nearest_hit_top RTL.
`default_nettype none

module ray_triangle_nearest_hit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    rtnh_pkg::status_t status;
    logic [15:0]       number;
    logic [30:0]       distance;
    logic [31:0]       u, v, hx, hy, hz;
  } hit_result_t;

  // Nearest-hit predictor and store of expected mesh results
  class hit_scoreboard;
    longint      ray_reg[6];
    longint      near_t, near_u, near_v;
    logic [15:0] near_num;
    bit          found;
    logic [15:0] tri_count;
    hit_result_t pending_hits[$];
    int          errors;

    function new();
      ray_reg = '{0, 0, 0, 0, 0, -ONE};
      clear_mesh();
      errors = 0;
    endfunction

    function void clear_mesh();
      near_t = 64'sd2147483647;
      near_num = '0;
      near_u = 0;
      near_v = 0;
      found = 0;
      tri_count = '0;
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint mulq(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    function longint qdiv(longint num, longint den);
      if (den == 0) return 0;
      return sat((num * ONE) / den);
    endfunction

    function longint dot(longint a[3], longint b[3]);
      return sat(mulq(a[0], b[0]) + mulq(a[1], b[1]) + mulq(a[2], b[2]));
    endfunction

    function void cross3(longint a[3], longint b[3], output longint r[3]);
      r[0] = sat(mulq(a[1], b[2]) - mulq(a[2], b[1]));
      r[1] = sat(mulq(a[2], b[0]) - mulq(a[0], b[2]));
      r[2] = sat(mulq(a[0], b[1]) - mulq(a[1], b[0]));
    endfunction

    function void set_reg(rtnh_pkg::cfg_reg_t idx, logic [31:0] val);
      ray_reg[idx] = longint'($signed(val));
    endfunction

    // Moller-Trumbore test of one triangle against the held ray
    function void test_triangle(longint vx[9]);
      longint e1[3], e2[3], dir[3], tv[3], p[3], q[3];
      longint det, u, v, t;
      for (int i = 0; i < 3; i++) begin
        e1[i] = sat(vx[3 + i] - vx[i]);
        e2[i] = sat(vx[6 + i] - vx[i]);
        dir[i] = ray_reg[3 + i];
        tv[i] = sat(ray_reg[i] - vx[i]);
      end
      cross3(dir, e2, p);
      det = dot(e1, p);
      if (det <= 1 && det >= -1) return;
      u = qdiv(dot(tv, p), det);
      if (u < -1 || u > ONE + 1) return;
      cross3(tv, e1, q);
      v = qdiv(dot(dir, q), det);
      if (v < -1 || sat(u + v) > ONE + 1) return;
      t = qdiv(dot(e2, q), det);
      if (t <= 1 || t >= near_t) return;
      near_t = t;
      near_num = tri_count;
      near_u = u;
      near_v = v;
      found = 1;
    endfunction

    // Note one accepted triangle; the last one of a mesh queues its result
    function void note_triangle(logic [287:0] data, bit last);
      longint vx[9];
      longint unsigned len2;
      hit_result_t r;
      for (int i = 0; i < 9; i++) vx[i] = longint'($signed(data[32*i +: 32]));
      test_triangle(vx);
      tri_count++;
      if (!last) return;
      r = '{rtnh_pkg::ST_NO_HIT, '0, '0, '0, '0, '0, '0, '0};
      len2 = longint'(ray_reg[3] * ray_reg[3]) + longint'(ray_reg[4] * ray_reg[4])
           + longint'(ray_reg[5] * ray_reg[5]);
      if ((len2 >> FRAC) <= 1) begin
        r.status = rtnh_pkg::ST_ZERO_DIR;
      end else if (found) begin
        r.status = rtnh_pkg::ST_HIT;
        r.number = near_num;
        r.distance = near_t[30:0];
        r.u = near_u[31:0];
        r.v = near_v[31:0];
        r.hx = 32'(sat(ray_reg[0] + mulq(ray_reg[3], near_t)));
        r.hy = 32'(sat(ray_reg[1] + mulq(ray_reg[4], near_t)));
        r.hz = 32'(sat(ray_reg[2] + mulq(ray_reg[5], near_t)));
      end
      pending_hits.push_back(r);
      clear_mesh();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [1:0] user, logic [207:0] data);
      hit_result_t w;
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result item", {30'd0, user}, '0);
        return;
      end
      w = pending_hits.pop_front();
      if (user != w.status) report_mismatch("status", user, w.status);
      if (data[15:0] != w.number) report_mismatch("triangle_number", data[15:0], w.number);
      if (data[46:16] != w.distance) report_mismatch("hit_distance", data[46:16], w.distance);
      if (data[78:47] != w.u) report_mismatch("weight_u", data[78:47], w.u);
      if (data[110:79] != w.v) report_mismatch("weight_v", data[110:79], w.v);
      if (data[142:111] != w.hx) report_mismatch("hit_x", data[142:111], w.hx);
      if (data[174:143] != w.hy) report_mismatch("hit_y", data[174:143], w.hy);
      if (data[206:175] != w.hz) report_mismatch("hit_z", data[206:175], w.hz);
      if (data[207] !== 1'b0) report_mismatch("pad bit", data[207], '0);
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [207:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  hit_scoreboard sb = new();
  bit     tx_idle_en;
  bit     rx_idle_en;
  int     rx_hold_left;
  longint cycles;

  ray_triangle_nearest_hit_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Timeout guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Accept and check result items; hold off on request
  initial begin
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 20);
      end
    end
  end

  // Offer one triangle and wait for its handshake
  task send_triangle(logic [287:0] data, bit last);
    if (tx_idle_en && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_triangle(data, last);
  endtask

  // Wait until every expected result has arrived and the engine is quiet
  task drain();
    s_axis_tvalid <= 0;
    while (sb.pending_hits.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load the ray while the engine is idle
  task set_ray(logic [31:0] o0, o1, o2, d0, d1, d2);
    logic [31:0] vals[6];
    vals = '{o0, o1, o2, d0, d1, d2};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_index <= rtnh_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(rtnh_pkg::cfg_reg_t'(i), vals[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic [287:0] pack_tri(longint vx[9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = vx[i][31:0];
    return d;
  endfunction

  function automatic logic [287:0] noise_tri();
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = $urandom;
    return d;
  endfunction

  // Triangle scattered around a point on the ray, so many of them are hit
  function automatic logic [287:0] near_ray_tri();
    longint t, pt[3], vx[9];
    int spread;
    t = longint'($urandom_range(1, 40)) * ONE + $urandom_range(0, 65535);
    spread = $urandom_range(1, 8);
    for (int i = 0; i < 3; i++) pt[i] = sb.sat(sb.ray_reg[i] + sb.mulq(sb.ray_reg[3 + i], t));
    for (int k = 0; k < 9; k++)
      vx[k] = sb.sat(pt[k % 3] + (longint'($urandom_range(0, 2 * spread * 65536))
                                  - spread * 65536));
    return pack_tri(vx);
  endfunction

  // One mesh of random length; mostly well-formed triangles, some noise
  task send_mesh(int n);
    for (int k = 0; k < n; k++)
      send_triangle(($urandom_range(99) < 85) ? near_ray_tri() : noise_tri(), k == n - 1);
  endtask

  function automatic logic [287:0] flat_tri(longint z, longint s, longint xo);
    longint vx[9];
    vx = '{xo - s, -s, z, xo + s, -s, z, xo, s, z};
    return pack_tri(vx);
  endfunction

  int sent;

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle_en = 0;
    rx_idle_en = 0;
    rx_hold_left = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default ray along -z
    send_triangle(flat_tri(-5 * ONE, ONE, 0), 1);                  // plain hit
    send_triangle(flat_tri(-5 * ONE, ONE, 10 * ONE), 0);           // outside triangle
    send_triangle(flat_tri(5 * ONE, ONE, 0), 0);                   // behind the origin
    send_triangle(pack_tri('{ONE, ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE}), 0); // det zero
    send_triangle(flat_tri(-7 * ONE, 2 * ONE, 0), 0);
    send_triangle(flat_tri(-3 * ONE, 2 * ONE, 0), 0);              // nearer wins
    send_triangle(flat_tri(-3 * ONE, 3 * ONE, 0), 0);              // equal distance, earlier wins
    send_triangle(flat_tri(-9 * ONE, ONE, 0), 1);
    send_triangle({9{32'h7FFF_FFFF}}, 0);                          // field extremes
    send_triangle({9{32'h8000_0000}}, 0);
    send_triangle({9{32'hFFFF_FFFF}}, 0);
    send_triangle('0, 1);
    send_triangle(flat_tri(-1, ONE, 0), 1);                        // distance of one LSB
    send_triangle(flat_tri(-2 * ONE, ONE, ONE), 1);                // outside, just beside an edge
    // Zero direction
    set_ray(0, 0, 0, 0, 0, 0);
    send_triangle(flat_tri(-5 * ONE, ONE, 0), 1);
    send_triangle(noise_tri(), 1);
    // Register extremes
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_triangle(noise_tri(), 0);
    send_triangle({9{32'h8000_0000}}, 1);
    sent = 18;

    // Random phases over several rays
    for (int ph = 0; sent < 900; ph++) begin
      case (ph % 7)
        0: set_ray(0, 0, 0, 0, 0, 32'hFFFF_0000);
        1: set_ray($urandom_range(0, 200 * 65536) - 100 * 65536, $urandom, $urandom_range(0, 65535),
                   32'h0001_0000, 0, 0);
        2: set_ray(3 * ONE, -2 * ONE, ONE, 0, 32'h0001_0000, 0);
        3: set_ray($urandom_range(0, 65535), 0, -ONE, 37837, 37837, 37837);
        4: set_ray(0, ONE, 0, 46341, 0, -46341);
        5: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_ray(0, 0, 0, $urandom_range(0, 3) - 1, 0, 1);
      endcase
      tx_idle_en = (ph % 4) != 1;
      rx_idle_en = (ph % 4) != 1;
      // Long receiver hold-off while the sender keeps offering
      if (ph == 3) rx_hold_left = 3000;
      for (int m = 0; m < 6 && sent < 900; m++) begin
        int n;
        n = $urandom_range(1, 8);
        send_mesh(n);
        sent += n;
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
